### rtl/core/ecam_pkg.sv
// ----------------------------------------------------------------------------
// ecam_pkg: shared types and constants of the camera orientation block
// payload structs, the token that runs through the series cells, the
// divisor and reciprocal tables of the sine and cosine series
// ----------------------------------------------------------------------------
package ecam_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int VEC_FRAC_BITS_DEF   = 14;

    localparam int N_CELLS      = 6;
    localparam int REDUCE_STEPS = 6;

    localparam logic [17:0] SENS_RESET = 18'd36045;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [34:0] PI_Q40     = 35'd19190098069;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic               clamp_pitch;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic               degenerate;
    } t_out_item;

    // one series evaluation in flight: x and x^2 in q.30, horner term t
    typedef struct packed {
        logic        vld;
        logic        is_sin;
        logic        is_pitch;
        logic [29:0] x;
        logic [29:0] x2;
        logic [30:0] t;
    } t_tok;

    typedef struct packed {
        logic        vld;
        logic        is_sin;
        logic        is_pitch;
        logic [30:0] val;
    } t_res;

    localparam logic [7:0]  SIN_DIV [0:4] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0]  COS_DIV [0:5] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    // floor(2^31 / divisor)
    localparam logic [30:0] SIN_MAG [0:4] = '{31'd19522578, 31'd29826161, 31'd51130563,
                                              31'd107374182, 31'd357913941};
    localparam logic [30:0] COS_MAG [0:5] = '{31'd16268815, 31'd23860929, 31'd38347922,
                                              31'd71582788, 31'd178956970, 31'd1073741824};

    // sine series is one term shorter, so it skips the first cell
    function automatic logic [7:0] cell_div(input int idx, input logic is_sin);
        logic [7:0] d;
        d = 8'd1;
        if (is_sin) begin
            if (idx > 0 && idx < 6) d = SIN_DIV[idx-1];
        end else if (idx < 6) begin
            d = COS_DIV[idx];
        end
        return d;
    endfunction

    function automatic logic [30:0] cell_mag(input int idx, input logic is_sin);
        logic [30:0] m;
        m = 31'd0;
        if (is_sin) begin
            if (idx > 0 && idx < 6) m = SIN_MAG[idx-1];
        end else if (idx < 6) begin
            m = COS_MAG[idx];
        end
        return m;
    endfunction

endpackage

### rtl/core/ecam_cell.sv
// ----------------------------------------------------------------------------
// ecam_cell: one horner step of the sine / cosine series
// t <= 1 - floor(floor(x2 * t) / d), three register stages, a token moves
// on every cycle
// ----------------------------------------------------------------------------
module ecam_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ecam_pkg::t_tok i_tok,
    output ecam_pkg::t_tok o_tok
);

    ecam_pkg::t_tok r_tok_a, r_tok_b, r_tok_c;
    ecam_pkg::t_tok n_tok_c;
    logic [29:0]    r_v_a, r_v_b, r_qe_b;

    logic [60:0] prod_a, prod_b;
    logic [30:0] mag_a;
    logic [7:0]  div_b;
    logic [37:0] qd;
    logic [30:0] rem;
    logic [29:0] q;
    logic        bypass;

    always_comb begin
        prod_a = {31'b0, i_tok.x2} * {30'b0, i_tok.t};
        mag_a  = ecam_pkg::cell_mag(IDX, r_tok_a.is_sin);
        prod_b = {31'b0, r_v_a} * {30'b0, mag_a};
        div_b  = ecam_pkg::cell_div(IDX, r_tok_b.is_sin);
        qd     = {8'b0, r_qe_b} * {30'b0, div_b};
        // reciprocal estimate is low by at most one
        rem    = {1'b0, r_v_b} - qd[30:0];
        q      = (rem >= {23'b0, div_b}) ? r_qe_b + 30'd1 : r_qe_b;
        bypass = (IDX == 0) && r_tok_b.is_sin;
        n_tok_c   = r_tok_b;
        n_tok_c.t = bypass ? r_tok_b.t : ecam_pkg::Q30_ONE - {1'b0, q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_a.vld <= 1'b0;
            r_tok_b.vld <= 1'b0;
            r_tok_c.vld <= 1'b0;
        end else begin
            r_tok_a   <= i_tok;
            r_v_a     <= prod_a[59:30];
            r_tok_b   <= r_tok_a;
            r_v_b     <= r_v_a;
            r_qe_b    <= prod_b[60:31];
            r_tok_c   <= n_tok_c;
        end
    end

    assign o_tok = r_tok_c;

endmodule

### rtl/core/ecam_chain.sv
// ----------------------------------------------------------------------------
// ecam_chain: row of series cells plus the closing stage
// sine tokens leave as x * t, cosine tokens as t, both q.30
// ----------------------------------------------------------------------------
module ecam_chain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ecam_pkg::t_tok i_tok,
    output ecam_pkg::t_res o_res
);

    ecam_pkg::t_tok w_link [0:ecam_pkg::N_CELLS];
    ecam_pkg::t_res r_res;
    logic [60:0]    prod;

    assign w_link[0] = i_tok;

    for (genvar g = 0; g < ecam_pkg::N_CELLS; g++) begin : g_cell
        ecam_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_link[g]),
            .o_tok   (w_link[g+1])
        );
    end

    always_comb begin
        prod = {31'b0, w_link[ecam_pkg::N_CELLS].x} * {30'b0, w_link[ecam_pkg::N_CELLS].t};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res.vld      <= w_link[ecam_pkg::N_CELLS].vld;
            r_res.is_sin   <= w_link[ecam_pkg::N_CELLS].is_sin;
            r_res.is_pitch <= w_link[ecam_pkg::N_CELLS].is_pitch;
            r_res.val      <= w_link[ecam_pkg::N_CELLS].is_sin ? {1'b0, prod[59:30]}
                                                               : w_link[ecam_pkg::N_CELLS].t;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/core/euler_camera_orientation.sv
// ----------------------------------------------------------------------------
// euler_camera_orientation: first-person camera orientation from mouse moves
// yaw / pitch accumulation, sine and cosine through a chain of horner cells,
// view, right and up vectors out
// ----------------------------------------------------------------------------
//   channel   | direction | handshake                 | payload
//   in        | input     | i_in_valid / o_in_stall   | i_in_data  (offsets, clamp)
//   out       | output    | o_out_valid / i_out_stall | o_out_data (vectors, flag)
//   cfg (apb) | input     | psel penable pwrite       | paddr pwdata prdata
//
// an item goes from transfer in to result valid through angle reduction, angle
// setup, issue of the yaw and pitch sine and cosine tokens, the cell pipeline
// (6 cells of 3 stages and the closing stage) and the build of the vectors
// one item is worked on at a time; in stalls high while it is in flight
// a waiting result sits in the output register; a new item waits only in ST_OUT
// synchronous active-low reset: yaw 270 degrees, pitch 0, sens (1/16 deg/px) 0.55
// ----------------------------------------------------------------------------
module euler_camera_orientation #(
    parameter int ANGLE_FRAC_BITS = ecam_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int VEC_FRAC_BITS   = ecam_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ecam_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ecam_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int A  = ANGLE_FRAC_BITS;
    localparam int V  = VEC_FRAC_BITS;
    localparam int AW = A + 9;
    localparam int SW = A + 16;
    localparam int RW = A + 7;
    localparam int MW = A + 6;
    localparam int LW = MW + 18;
    localparam int HW = MW + 17;
    localparam int VW = V + 2;
    localparam int PW = 2 * VW;
    localparam int RS = 20 - A;

    localparam logic signed [SW-1:0] D360   = SW'(64'd360 << A);
    localparam logic signed [SW-1:0] D360_32 = SW'(64'd360 << (A + 5));
    localparam logic signed [SW-1:0] D180   = SW'(64'd180 << A);
    localparam logic signed [SW-1:0] D89    = SW'(64'd89 << A);
    localparam logic [AW-1:0] A90  = AW'(64'd90 << A);
    localparam logic [AW-1:0] A180 = AW'(64'd180 << A);
    localparam logic [AW-1:0] A270 = AW'(64'd270 << A);
    localparam logic [AW-1:0] A360 = AW'(64'd360 << A);
    localparam logic [RW-1:0] R90  = RW'(64'd90 << A);
    localparam logic [RW-1:0] R45  = RW'(64'd45 << A);
    localparam logic [AW-1:0] YAW_RESET = AW'(64'd270 << A);
    localparam logic [17:0] PI_LO = ecam_pkg::PI_Q40[17:0];
    localparam logic [16:0] PI_HI = ecam_pkg::PI_Q40[34:18];

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM, ST_RED, ST_ANG, ST_WRAP, ST_QUAD, ST_MIR, ST_PI1,
        ST_PI2, ST_SQ, ST_ISSUE, ST_WAIT, ST_VEC, ST_MUL, ST_OUT
    } t_state;

    t_state                r_state;
    logic [17:0]           r_sens;
    logic [AW-1:0]         r_yaw;
    logic signed [AW-1:0]  r_pitch;
    logic signed [34:0]    r_dxp, r_dyp;
    logic                  r_clamp;
    logic signed [SW-1:0]  r_ys, r_ps;
    logic [2:0]            r_k;
    logic [1:0]            r_cnt;
    logic [AW-1:0]         r_ang  [0:1];
    logic [1:0]            r_quad [0:1];
    logic [RW-1:0]         r_rem  [0:1];
    logic [MW-1:0]         r_rm   [0:1];
    logic                  r_swap [0:1];
    logic [LW-1:0]         r_lo   [0:1];
    logic [HW-1:0]         r_hi   [0:1];
    logic [29:0]           r_x    [0:1];
    logic [29:0]           r_x2   [0:1];
    logic [30:0]           r_q30  [0:3];
    logic signed [VW-1:0]  r_sn   [0:1];
    logic signed [VW-1:0]  r_cs   [0:1];
    logic signed [PW-1:0]  r_pdx, r_pdz, r_pux, r_puz;
    logic signed [VW-1:0]  r_rx, r_rz, r_uy, r_dy;
    logic                  r_degen;
    logic                  r_out_vld;
    ecam_pkg::t_out_item   r_out;

    ecam_pkg::t_tok        w_tok;
    ecam_pkg::t_res        w_res;

    logic signed [36:0]    dx_w, dy_w;
    logic signed [SW-1:0]  ys0, ys, ps0, pt, ps, thr;
    logic                  cfg_wr, out_free, neg_g;
    logic signed [VW-1:0]  ngcy, ngsy;
    logic [AW-1:0]         pa;
    logic [AW-1:0]         qsub   [0:1];
    logic [1:0]            qsel   [0:1];
    logic [63:0]           full   [0:1];
    logic [59:0]           sq     [0:1];
    logic signed [VW-1:0]  sv     [0:1];
    logic signed [VW-1:0]  cv     [0:1];
    ecam_pkg::t_out_item   nxt_out;

    function automatic logic signed [VW-1:0] q30v(input logic [30:0] v);
        logic [31:0] tmp;
        tmp = {1'b0, v} + (32'd1 << (29 - V));
        return $signed({1'b0, tmp[30-V +: V+1]});
    endfunction

    function automatic logic signed [15:0] rnd16(input logic signed [PW-1:0] p);
        logic signed [63:0] e;
        e = 64'(p) + (64'sd1 <<< (V - 1));
        return e[V+15:V];
    endfunction

    ecam_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok),
        .o_res   (w_res)
    );

    always_comb begin
        cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
        // round half up to the angle grid, no rounding bias when shift is zero
        dx_w = ($signed({r_dxp[34], r_dxp, 1'b0}) + (37'sd1 <<< RS)) >>> (RS + 1);
        dy_w = ($signed({r_dyp[34], r_dyp, 1'b0}) + (37'sd1 <<< RS)) >>> (RS + 1);

        ys0 = $signed({{(SW-AW){1'b0}}, r_yaw}) + SW'(dx_w);
        ys  = (ys0 < 0) ? ys0 + D360_32 : ys0;
        ps0 = SW'(r_pitch) + SW'(dy_w);
        pt  = ps0 + D180;
        if (r_clamp) begin
            ps = (ps0 > D89) ? D89 : ((ps0 < -D89) ? -D89 : ps0);
        end else begin
            ps = (pt < 0) ? pt + D360_32 : pt;
        end
        thr = D360 <<< r_k;

        pa = r_pitch[AW-1] ? $unsigned(r_pitch) + A360 : $unsigned(r_pitch);

        for (int i = 0; i < 2; i++) begin
            if (r_ang[i] >= A270) begin
                qsel[i] = 2'd3;
                qsub[i] = A270;
            end else if (r_ang[i] >= A180) begin
                qsel[i] = 2'd2;
                qsub[i] = A180;
            end else if (r_ang[i] >= A90) begin
                qsel[i] = 2'd1;
                qsub[i] = A90;
            end else begin
                qsel[i] = 2'd0;
                qsub[i] = '0;
            end
            full[i] = (64'(r_hi[i]) << 18) + 64'(r_lo[i]) + (64'd1 << (9 + A));
            sq[i]   = 60'(r_x[i]) * 60'(r_x[i]);
            sv[i]   = q30v(r_swap[i] ? r_q30[{i[0], 1'b0}] : r_q30[{i[0], 1'b1}]);
            cv[i]   = q30v(r_swap[i] ? r_q30[{i[0], 1'b1}] : r_q30[{i[0], 1'b0}]);
        end

        neg_g = r_cs[1] < 0;
        ngcy  = neg_g ? r_cs[0] : -r_cs[0];
        ngsy  = neg_g ? r_sn[0] : -r_sn[0];

        w_tok.vld      = (r_state == ST_ISSUE);
        w_tok.is_sin   = ~r_k[0];
        w_tok.is_pitch = r_k[1];
        w_tok.x        = r_x[r_k[1]];
        w_tok.x2       = r_x2[r_k[1]];
        w_tok.t        = ecam_pkg::Q30_ONE;

        nxt_out.dir_x      = rnd16(r_pdx);
        nxt_out.dir_y      = 16'(r_dy);
        nxt_out.dir_z      = rnd16(r_pdz);
        nxt_out.right_x    = r_degen ? '0 : 16'(r_rx);
        nxt_out.right_z    = r_degen ? '0 : 16'(r_rz);
        nxt_out.up_x       = r_degen ? '0 : rnd16(r_pux);
        nxt_out.up_y       = r_degen ? '0 : 16'(r_uy);
        nxt_out.up_z       = r_degen ? '0 : rnd16(r_puz);
        nxt_out.degenerate = r_degen;

        out_free = !r_out_vld || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sens    <= ecam_pkg::SENS_RESET;
            r_yaw     <= YAW_RESET;
            r_pitch   <= '0;
            r_k       <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_sens <= pwdata[17:0];
            end
            // in the output state a free register is refilled below
            if (r_out_vld && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_vld <= 1'b0;
            end
            if (w_res.vld) begin
                r_q30[{w_res.is_pitch, w_res.is_sin}] <= w_res.val;
                r_cnt <= r_cnt + 2'd1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_dxp   <= i_in_data.offset_x * $signed({1'b0, r_sens});
                        r_dyp   <= i_in_data.offset_y * $signed({1'b0, r_sens});
                        r_clamp <= i_in_data.clamp_pitch;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_ys    <= ys;
                    r_ps    <= ps;
                    r_k     <= 3'(ecam_pkg::REDUCE_STEPS - 1);
                    r_state <= ST_RED;
                end
                ST_RED: begin
                    // restoring reduction by 360 * 2^k
                    if (r_ys >= thr) r_ys <= r_ys - thr;
                    if (!r_clamp && (r_ps >= thr)) r_ps <= r_ps - thr;
                    r_k <= r_k - 3'd1;
                    if (r_k == 3'd0) r_state <= ST_ANG;
                end
                ST_ANG: begin
                    r_yaw   <= r_ys[AW-1:0];
                    r_pitch <= r_clamp ? r_ps[AW-1:0] : AW'(r_ps - D180);
                    r_state <= ST_WRAP;
                end
                ST_WRAP: begin
                    r_ang[0] <= r_yaw;
                    r_ang[1] <= pa;
                    r_state  <= ST_QUAD;
                end
                ST_QUAD: begin
                    for (int i = 0; i < 2; i++) begin
                        r_quad[i] <= qsel[i];
                        r_rem[i]  <= RW'(r_ang[i] - qsub[i]);
                    end
                    r_state <= ST_MIR;
                end
                ST_MIR: begin
                    // residual above 45 mirrors and swaps sine and cosine
                    for (int i = 0; i < 2; i++) begin
                        r_swap[i] <= r_rem[i] > R45;
                        r_rm[i]   <= (r_rem[i] > R45) ? MW'(R90 - r_rem[i]) : MW'(r_rem[i]);
                    end
                    r_state <= ST_PI1;
                end
                ST_PI1: begin
                    for (int i = 0; i < 2; i++) begin
                        r_lo[i] <= LW'(r_rm[i]) * LW'(PI_LO);
                        r_hi[i] <= HW'(r_rm[i]) * HW'(PI_HI);
                    end
                    r_state <= ST_PI2;
                end
                ST_PI2: begin
                    for (int i = 0; i < 2; i++) begin
                        r_x[i] <= full[i][A+10 +: 30];
                    end
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    for (int i = 0; i < 2; i++) begin
                        r_x2[i] <= sq[i][59:30];
                    end
                    r_k     <= '0;
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd3) r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_res.vld && (r_cnt == 2'd3)) r_state <= ST_VEC;
                end
                ST_VEC: begin
                    for (int i = 0; i < 2; i++) begin
                        case (r_quad[i])
                            2'd0: begin
                                r_sn[i] <= sv[i];
                                r_cs[i] <= cv[i];
                            end
                            2'd1: begin
                                r_sn[i] <= cv[i];
                                r_cs[i] <= -sv[i];
                            end
                            2'd2: begin
                                r_sn[i] <= -sv[i];
                                r_cs[i] <= -cv[i];
                            end
                            default: begin
                                r_sn[i] <= -cv[i];
                                r_cs[i] <= sv[i];
                            end
                        endcase
                    end
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_pdx   <= r_cs[0] * r_cs[1];
                    r_pdz   <= r_sn[0] * r_cs[1];
                    r_pux   <= ngcy * r_sn[1];
                    r_puz   <= ngsy * r_sn[1];
                    r_rx    <= ngsy;
                    r_rz    <= -ngcy;
                    r_uy    <= neg_g ? -r_cs[1] : r_cs[1];
                    r_dy    <= r_sn[1];
                    r_degen <= (r_cs[1] == '0);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out     <= nxt_out;
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == 1'b0) ? {14'b0, r_sens} : 32'b0;

    // stored yaw stays inside one turn
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw < A360)
        else $error("yaw out of range");

    // series results only come back while the sequencer waits for them
    a_res_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.vld |-> (r_state == ST_WAIT))
        else $error("series result outside wait");

    // degenerate view gives zero right and up vectors
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |->
        (o_out_data.right_x == '0 && o_out_data.right_z == '0 &&
         o_out_data.up_x == '0 && o_out_data.up_y == '0 && o_out_data.up_z == '0))
        else $error("degenerate result with nonzero basis");

    // an item offered while idle is taken and starts the sequence in the sum state
    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_SUM))
        else $error("accepted item not started");

endmodule

### verif/tb_euler_camera_orientation.sv
// ----------------------------------------------------------------------------
// tb_euler_camera_orientation: self-checking bench of the camera orientation
// mouse moves are driven through a queue with random gaps, the monitor takes
// results under random stall and checks every field against a local
// fixed-point model of yaw/pitch accumulation, series trig and the vectors
// ----------------------------------------------------------------------------
module tb_euler_camera_orientation;

    localparam int AFB = 16;
    localparam int VFB = 14;
    localparam longint DEG_ONE = longint'(1) << AFB;
    localparam longint DEG_360 = 360 * DEG_ONE;
    localparam longint DEG_180 = 180 * DEG_ONE;
    localparam longint DEG_90  = 90 * DEG_ONE;
    localparam longint DEG_89  = 89 * DEG_ONE;
    localparam longint DEG_45  = 45 * DEG_ONE;
    localparam logic [2:0] ADDR_SENS = 3'd0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    ecam_pkg::t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    ecam_pkg::t_out_item out_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    euler_camera_orientation i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // camera state of the prediction
    longint cam_sens, cam_yaw, cam_pitch;
    ecam_pkg::t_in_item move_q[$];
    ecam_pkg::t_out_item view_q[$];
    int n_errors = 0;
    int n_moves = 0;
    int n_views = 0;
    int n_degenerate = 0;
    bit hold_sender = 1'b0;
    bit long_hold = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(longint v, int s);
        if (s == 0) return v;
        return floor_shr(v + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint modulo(longint v, longint n);
        longint m;
        m = v % n;
        if (m < 0) m += n;
        return m;
    endfunction

    function automatic longint q30_vec(logic [63:0] v);
        return longint'((v + (64'd1 << (29 - VFB))) >> (30 - VFB));
    endfunction

    task automatic trig(input longint angle, output longint sn, output longint cs);
        longint a, quad, r, s, c;
        logic [63:0] x, x2, t, sq, cq;
        logic [127:0] wide;
        bit swap;
        int dv_s[5];
        int dv_c[6];
        dv_s = '{110, 72, 42, 20, 6};
        dv_c = '{132, 90, 56, 30, 12, 2};
        a = modulo(angle, DEG_360);
        quad = a / DEG_90;
        r = a % DEG_90;
        swap = 1'b0;
        if (r > DEG_45) begin
            r = DEG_90 - r;
            swap = 1'b1;
        end
        wide = 128'(r) * 128'(ecam_pkg::PI_Q40) + (128'd1 << (9 + AFB));
        x = 64'(wide >> (10 + AFB));
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv_s[i];
        sq = (x * t) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv_c[i];
        cq = t;
        s = q30_vec(swap ? cq : sq);
        c = q30_vec(swap ? sq : cq);
        case (quad)
            0: begin sn = s; cs = c; end
            1: begin sn = c; cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    function automatic longint vmul(longint a, longint b);
        return round_shr(a * b, VFB);
    endfunction

    task automatic predict_view(input ecam_pkg::t_in_item m);
        longint dx, dy, p, sy, cy, sp, cp, g;
        ecam_pkg::t_out_item v;
        dx = round_shr(longint'(m.offset_x) * cam_sens, 20 - AFB);
        dy = round_shr(longint'(m.offset_y) * cam_sens, 20 - AFB);
        cam_yaw = modulo(cam_yaw + dx, DEG_360);
        p = cam_pitch + dy;
        if (m.clamp_pitch) begin
            if (p > DEG_89) p = DEG_89;
            if (p < -DEG_89) p = -DEG_89;
        end else begin
            p = modulo(p + DEG_180, DEG_360) - DEG_180;
        end
        cam_pitch = p;
        trig(cam_yaw, sy, cy);
        trig(cam_pitch, sp, cp);
        v = '0;
        v.dir_x = 16'(vmul(cy, cp));
        v.dir_y = 16'(sp);
        v.dir_z = 16'(vmul(sy, cp));
        if (cp == 0) begin
            v.degenerate = 1'b1;
        end else begin
            g = (cp > 0) ? 1 : -1;
            v.right_x = 16'(-g * sy);
            v.right_z = 16'(g * cy);
            v.up_x = 16'(vmul(-g * cy, sp));
            v.up_y = 16'(g * cp);
            v.up_z = 16'(vmul(-g * sy, sp));
        end
        view_q.push_back(v);
    endtask

    // driver
    int gap = 0;
    always @(posedge clk) begin
        ecam_pkg::t_in_item m;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_view(in_data);
                n_moves++;
                void'(move_q.pop_front());
                gap = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if (in_valid && in_stall) begin
                // hold the stalled payload
            end else if (move_q.size() > 0 && !hold_sender && gap == 0) begin
                m = move_q[0];
                in_data <= m;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
                if (gap > 0) gap--;
            end
        end
    end

    // monitor and receiver stall
    int stall_cnt = 0;
    always @(posedge clk) begin
        ecam_pkg::t_out_item e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (view_q.size() == 0) begin
                    $error("result with no expectation");
                    n_errors++;
                end else begin
                    e = view_q.pop_front();
                    n_views++;
                    if (e.degenerate) n_degenerate++;
                    if (out_data.dir_x !== e.dir_x) begin
                        $error("dir_x exp %0d got %0d", e.dir_x, out_data.dir_x); n_errors++; end
                    if (out_data.dir_y !== e.dir_y) begin
                        $error("dir_y exp %0d got %0d", e.dir_y, out_data.dir_y); n_errors++; end
                    if (out_data.dir_z !== e.dir_z) begin
                        $error("dir_z exp %0d got %0d", e.dir_z, out_data.dir_z); n_errors++; end
                    if (out_data.right_x !== e.right_x) begin
                        $error("right_x exp %0d got %0d", e.right_x, out_data.right_x);
                        n_errors++; end
                    if (out_data.right_z !== e.right_z) begin
                        $error("right_z exp %0d got %0d", e.right_z, out_data.right_z);
                        n_errors++; end
                    if (out_data.up_x !== e.up_x) begin
                        $error("up_x exp %0d got %0d", e.up_x, out_data.up_x); n_errors++; end
                    if (out_data.up_y !== e.up_y) begin
                        $error("up_y exp %0d got %0d", e.up_y, out_data.up_y); n_errors++; end
                    if (out_data.up_z !== e.up_z) begin
                        $error("up_z exp %0d got %0d", e.up_z, out_data.up_z); n_errors++; end
                    if (out_data.degenerate !== e.degenerate) begin
                        $error("degenerate exp %0d got %0d", e.degenerate, out_data.degenerate);
                        n_errors++; end
                end
            end
            if (long_hold) begin
                out_stall <= 1'b1;
                stall_cnt = 0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                out_stall <= 1'b1;
            end else if ($urandom_range(0, 1) == 0) begin
                stall_cnt = $urandom_range(0, 15);
                out_stall <= (stall_cnt > 0);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_SENS) cam_sens = longint'(data[17:0]);
    endtask

    task automatic drain();
        wait (move_q.size() == 0 && !in_valid);
        wait (view_q.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic add_move(input int ox, input int oy, input bit cl);
        ecam_pkg::t_in_item m;
        m.offset_x = 16'(ox);
        m.offset_y = 16'(oy);
        m.clamp_pitch = cl;
        move_q.push_back(m);
    endtask

    task automatic random_moves(input int n);
        int ox, oy;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0: begin ox = $urandom; oy = $urandom; end
                1: begin
                    ox = $urandom_range(0, 4000) - 2000;
                    oy = $urandom_range(0, 4000) - 2000;
                end
                2: begin ox = $urandom_range(0, 64) - 32; oy = $urandom_range(0, 64) - 32; end
                3: begin ox = $urandom; oy = ($urandom_range(0, 1) ? 32767 : -32768); end
                default: begin ox = $urandom_range(0, 400) - 200; oy = $urandom; end
            endcase
            add_move(ox, oy, $urandom_range(0, 1));
        end
    endtask

    initial begin
        cam_sens = 36045;
        cam_yaw = 270 * DEG_ONE;
        cam_pitch = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, clamp both ways, wrap past vertical, exact vertical pitch
        add_move(0, 0, 0);
        add_move(32767, 32767, 0);
        add_move(-32768, -32768, 0);
        add_move(32767, 32767, 1);
        add_move(-32768, -32768, 1);
        add_move(1, -1, 0);
        add_move(-1, 1, 1);
        add_move(16'h5555, 16'haaaa, 0);
        add_move(16'haaaa, 16'h5555, 1);
        drain();
        apb_write(ADDR_SENS, 32'd65536);         // 1/16 degree per pixel
        add_move(0, 1440, 0);                    // pitch 89 to 179 degrees
        add_move(0, 16, 0);                      // pitch wraps to -180
        add_move(0, 1440, 0);
        add_move(0, -32, 0);
        add_move(160, -2880, 0);
        add_move(-5760, 0, 1);
        drain();
        apb_write(ADDR_SENS, 32'd0);
        add_move(12345, -23456, 0);
        add_move(-1, 1, 1);
        drain();
        apb_write(ADDR_SENS, 32'hffff_ffff);     // top of range
        add_move(32767, -32768, 0);
        add_move(-32768, 32767, 1);
        add_move(100, 100, 0);
        drain();

        // random phases over several sensitivities
        apb_write(ADDR_SENS, 32'd36045);
        random_moves(100);
        // long receiver hold while the sender keeps offering
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        drain();
        apb_write(ADDR_SENS, $urandom_range(0, 262143));
        random_moves(100);
        drain();
        apb_write(ADDR_SENS, 32'd262143);
        random_moves(80);
        // let some moves through, then the sender pauses until every result is in
        repeat (300) @(posedge clk);
        hold_sender = 1'b1;
        wait (view_q.size() == 0 && !in_valid);
        hold_sender = 1'b0;
        drain();
        apb_write(ADDR_SENS, $urandom_range(1, 4096));
        random_moves(100);
        drain();

        $display("covered %0d moves, %0d views (%0d degenerate) over several sensitivity settings",
                 n_moves, n_views, n_degenerate);
        if (n_errors == 0) begin
            $display("euler_camera_orientation regression: pass");
        end else begin
            $display("euler_camera_orientation regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("euler_camera_orientation regression: fail");
        $finish;
    end
endmodule

### sim.f
rtl/core/ecam_pkg.sv
rtl/core/ecam_cell.sv
rtl/core/ecam_chain.sv
rtl/core/euler_camera_orientation.sv
verif/tb_euler_camera_orientation.sv
